// ===== design/complex_matrix_multiply_accumulate_core_defines.svh =====
// Assertion macros shared by the complex matrix multiply-accumulate RTL.
`ifndef COMPLEX_MATRIX_MULTIPLY_ACCUMULATE_CORE_DEFINES_SVH
`define COMPLEX_MATRIX_MULTIPLY_ACCUMULATE_CORE_DEFINES_SVH

// Same-cycle check, clocked on clk_i, off while rst_ni is low.
`define CMMA_ASSERT(lbl_, prop_, msg_) \
  lbl_: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop_)) \
    else $error(msg_);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define CMMA_ASSERT_NEXT(lbl_, ante_, cons_, msg_) \
  lbl_: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante_) |=> (cons_)) \
    else $error(msg_);

`endif

// ===== design/cmma_pkg.sv =====
// Types, codes and saturation helpers of the complex matrix multiply-accumulate core.
package cmma_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SIZE_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int TDATA_W    = 80;

  typedef logic signed [31:0] cmma_word_t;
  typedef logic signed [63:0] cmma_wide_t;

  typedef struct packed {
    cmma_word_t im;
    cmma_word_t re;
  } cmma_cval_t;

  typedef enum logic [1:0] {
    CMD_WR_A    = 2'd0,
    CMD_WR_B    = 2'd1,
    CMD_WR_C    = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmma_cmd_e;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_N   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_RE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_IM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_RE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA_IM  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } cmma_state_e;

  // Clip a 65-bit sum to 64 bits.
  function automatic cmma_wide_t cmma_sat64(input logic signed [64:0] v);
    cmma_wide_t r;
    if (v[64] != v[63]) begin
      r = v[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
    end else begin
      r = v[63:0];
    end
    return r;
  endfunction

  function automatic logic cmma_fits32(input cmma_wide_t v);
    return (&v[63:31]) || !(|v[63:31]);
  endfunction

  function automatic cmma_word_t cmma_sat32(input cmma_wide_t v);
    cmma_word_t r;
    if (cmma_fits32(v)) begin
      r = v[31:0];
    end else begin
      r = v[63] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== design/cmma_cmul.sv =====
// Two-stage complex multiplier: exact products, then saturating sum and arithmetic shift.
module cmma_cmul (
  input  logic                  clk_i,
  input  cmma_pkg::cmma_cval_t  a_i,
  input  cmma_pkg::cmma_cval_t  b_i,
  output cmma_pkg::cmma_wide_t  re_o,
  output cmma_pkg::cmma_wide_t  im_o
);
  import cmma_pkg::*;

  cmma_wide_t p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  cmma_wide_t re_q, im_q;
  cmma_wide_t sat_re, sat_im;
  logic signed [64:0] sum_re, sum_im;

  always_ff @(posedge clk_i) begin
    p_rr_q <= $signed(a_i.re) * $signed(b_i.re);
    p_ii_q <= $signed(a_i.im) * $signed(b_i.im);
    p_ri_q <= $signed(a_i.re) * $signed(b_i.im);
    p_ir_q <= $signed(a_i.im) * $signed(b_i.re);
  end

  always_comb begin
    sum_re = {p_rr_q[63], p_rr_q} - {p_ii_q[63], p_ii_q};
    sum_im = {p_ri_q[63], p_ri_q} + {p_ir_q[63], p_ir_q};
    sat_re = cmma_sat64(sum_re);
    sat_im = cmma_sat64(sum_im);
  end

  // floor shift
  always_ff @(posedge clk_i) begin
    re_q <= sat_re >>> FRAC_BITS;
    im_q <= sat_im >>> FRAC_BITS;
  end

  assign re_o = re_q;
  assign im_o = im_q;

endmodule

// ===== design/complex_matrix_multiply_accumulate_core.sv =====
// Complex matrix multiply-accumulate core: C = beta*C + alpha*A*B, one element per request.
//
// Input stream (s_axis): tuser carries the command, tdata the element index and value.
// Commands write one element of A, B or C (no response) or compute one element of C.
// A compute request reads C[row,col] and walks n = 0..min(size_n, MAX_N)-1 through the A and B
// memories, one complex term per cycle, then writes the new C element back and
// sends it on the output stream (m_axis) with a saturation flag in tuser.
// A write request leaves the core idle and ready for the next request. A compute request
// occupies the core from accept to result: one read of the A and B memories per term,
// plus the memory read register and the two 2-stage complex multipliers behind it.
// The next request is taken the cycle after the result is loaded into the output
// register, so a waiting result does not block the input side; a second result
// waits in the core until the receiver takes the first one.
// Configuration writes (size_n, alpha, beta) land on the clock edge where cfg_we_i
// is high; the user must make them only while the core is idle, the core does not enforce it.
// Reset clears control state and the configuration to size_n 1, alpha 1.0, beta 0;
// the matrix memories are not cleared and must be written before they are read.
`include "complex_matrix_multiply_accumulate_core_defines.svh"

module complex_matrix_multiply_accumulate_core #(
  parameter int MAX_N = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // row[5:0], col[11:6], value_re[43:12], value_im[75:44], zero pad
  input  logic [cmma_pkg::TDATA_W-1:0]        s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_row[5:0], out_col[11:6], out_re[43:12], out_im[75:44], zero pad
  output logic [cmma_pkg::TDATA_W-1:0]        m_axis_tdata,
  // saturated[0]
  output logic [0:0]                          m_axis_tuser,
  input  logic                                cfg_we_i,
  input  logic [cmma_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cmma_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import cmma_pkg::*;

  localparam int IW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int DEPTH = MAX_N * MAX_N;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_N + 2);

  // ---------------- input unpack ----------------
  cmma_cmd_e   in_cmd;
  logic [5:0]  in_row, in_col;
  cmma_cval_t  in_val;
  logic [IW-1:0] in_ridx, in_cidx;
  logic [AW-1:0] in_at;
  logic        in_acc;

  assign in_cmd = cmma_cmd_e'(s_axis_tuser);
  assign in_row = s_axis_tdata[5:0];
  assign in_col = s_axis_tdata[11:6];
  assign in_val = cmma_cval_t'({s_axis_tdata[75:44], s_axis_tdata[43:12]});
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // index reduced into the store
  logic [IW-1:0] mod_tab [64];
  for (genvar g = 0; g < 64; g++) begin : g_mod
    assign mod_tab[g] = IW'(g % MAX_N);
  end

  assign in_ridx = mod_tab[in_row];
  assign in_cidx = mod_tab[in_col];
  assign in_at   = AW'(in_cidx) * AW'(MAX_N) + AW'(in_ridx);

  // ---------------- configuration ----------------
  logic [SIZE_W-1:0] size_q;
  cmma_cval_t        alpha_q, beta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q     <= SIZE_W'(1);
      alpha_q.re <= 32'sd65536;
      alpha_q.im <= '0;
      beta_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIZE_N:   size_q     <= cfg_data_i[SIZE_W-1:0];
        CFG_ALPHA_RE: alpha_q.re <= cfg_data_i;
        CFG_ALPHA_IM: alpha_q.im <= cfg_data_i;
        CFG_BETA_RE:  beta_q.re  <= cfg_data_i;
        CFG_BETA_IM:  beta_q.im  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- control ----------------
  cmma_state_e   state_q, state_d;
  logic [CW-1:0] slot_q, nn_q, n_cnt;
  logic [6:1]    vld_q;
  logic [6:1]    init_q;
  logic          issue_more, issue_en, fin_load, out_free;
  logic          m_valid_q;
  logic [5:0]    row_q, col_q;
  logic [IW-1:0] ridx_q, cidx_q, term_idx;
  logic [AW-1:0] at_q;
  logic          clip_q;

  assign issue_more = (slot_q <= nn_q);
  assign out_free   = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc && in_cmd == CMD_COMPUTE) state_d = ST_RUN;
      ST_RUN:    if (!issue_more && vld_q == '0) state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    issue_en      = 1'b0;
    fin_load      = 1'b0;
    unique case (state_q)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_RUN:    issue_en      = issue_more;
      ST_FINISH: fin_load      = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= '0;
      vld_q   <= '0;
      init_q  <= '0;
    end else begin
      state_q <= state_d;
      vld_q   <= {vld_q[5:1], issue_en};
      init_q  <= {init_q[5:1], issue_en && slot_q == '0};
      if (in_acc) begin
        slot_q <= '0;
      end else if (issue_en) begin
        slot_q <= slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_cmd == CMD_COMPUTE) begin
      row_q  <= in_row;
      col_q  <= in_col;
      ridx_q <= in_ridx;
      cidx_q <= in_cidx;
      at_q   <= in_at;
      nn_q   <= (int'(size_q) > MAX_N) ? CW'(MAX_N) : CW'(size_q);
    end
  end

  // slot 0 reads C, slot k reads term n = k-1
  assign n_cnt = (slot_q == '0) ? '0 : slot_q - 1'b1;

  if (MAX_N > 64) begin : g_wide_idx
    assign term_idx = IW'(n_cnt[5:0]);
  end else begin : g_narrow_idx
    assign term_idx = n_cnt[IW-1:0];
  end

  // ---------------- memories ----------------
  logic [AW-1:0] a_raddr, b_raddr, c_waddr;
  cmma_cval_t    a_rd_q, b_rd_q, c_rd_q, c_wdata, res;
  logic          c_we;

  assign a_raddr = AW'(term_idx) * AW'(MAX_N) + AW'(ridx_q);
  assign b_raddr = AW'(cidx_q) * AW'(MAX_N) + AW'(term_idx);

  cmma_cval_t a_mem [DEPTH];
  cmma_cval_t b_mem [DEPTH];
  cmma_cval_t c_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (in_acc && in_cmd == CMD_WR_A) begin
      a_mem[in_at] <= in_val;
    end
    a_rd_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_cmd == CMD_WR_B) begin
      b_mem[in_at] <= in_val;
    end
    b_rd_q <= b_mem[b_raddr];
  end

  // write requests and result write-back never share a cycle
  assign c_we    = (in_acc && in_cmd == CMD_WR_C) || fin_load;
  assign c_waddr = fin_load ? at_q : in_at;
  assign c_wdata = fin_load ? res : in_val;

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      c_mem[c_waddr] <= c_wdata;
    end
    c_rd_q <= c_mem[at_q];
  end

  // ---------------- datapath ----------------
  cmma_cval_t op1_a, op1_b, op2_b;
  cmma_wide_t m1_re, m1_im, m2_re, m2_im;
  cmma_wide_t mid_re_q, mid_im_q, acc_re_q, acc_im_q;
  logic       fin_clip;

  assign op1_a = init_q[1] ? beta_q : a_rd_q;
  assign op1_b = init_q[1] ? c_rd_q : b_rd_q;

  cmma_cmul u_cmul_ab (
    .clk_i (clk_i),
    .a_i   (op1_a),
    .b_i   (op1_b),
    .re_o  (m1_re),
    .im_o  (m1_im)
  );

  // beta*C stays wide; an A*B term is clipped to 32 bits
  always_ff @(posedge clk_i) begin
    if (vld_q[3]) begin
      if (init_q[3]) begin
        mid_re_q <= m1_re;
        mid_im_q <= m1_im;
      end else begin
        mid_re_q <= cmma_wide_t'(cmma_sat32(m1_re));
        mid_im_q <= cmma_wide_t'(cmma_sat32(m1_im));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_cmd == CMD_COMPUTE) begin
      clip_q <= 1'b0;
    end else if (vld_q[3] && !init_q[3] && (!cmma_fits32(m1_re) || !cmma_fits32(m1_im))) begin
      clip_q <= 1'b1;
    end
  end

  assign op2_b = cmma_cval_t'({mid_im_q[31:0], mid_re_q[31:0]});

  cmma_cmul u_cmul_alpha (
    .clk_i (clk_i),
    .a_i   (alpha_q),
    .b_i   (op2_b),
    .re_o  (m2_re),
    .im_o  (m2_im)
  );

  // the beta*C start value lands in the accumulator before the first term is added;
  // the start slot itself never passes through the alpha product
  always_ff @(posedge clk_i) begin
    if (vld_q[4] && init_q[4]) begin
      acc_re_q <= mid_re_q;
      acc_im_q <= mid_im_q;
    end else if (vld_q[6] && !init_q[6]) begin
      acc_re_q <= cmma_sat64({acc_re_q[63], acc_re_q} + {m2_re[63], m2_re});
      acc_im_q <= cmma_sat64({acc_im_q[63], acc_im_q} + {m2_im[63], m2_im});
    end
  end

  assign res.re   = cmma_sat32(acc_re_q);
  assign res.im   = cmma_sat32(acc_im_q);
  assign fin_clip = clip_q || !cmma_fits32(acc_re_q) || !cmma_fits32(acc_im_q);

  // ---------------- output register ----------------
  logic [TDATA_W-1:0] m_data_q;
  logic               m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (fin_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      m_data_q <= {4'b0000, res.im, res.re, col_q, row_q};
      m_user_q <= fin_clip;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;

  // ---------------- assertions ----------------
  `CMMA_ASSERT(a_init_no_overlap, !(vld_q[4] && init_q[4] && vld_q[6]),
    "accumulator start value collides with a term")
  `CMMA_ASSERT(a_finish_drained, (state_q != ST_FINISH) || (vld_q == '0),
    "result taken while terms are still in flight")
  `CMMA_ASSERT(a_slot_bound, (state_q != ST_RUN) || (slot_q <= nn_q + 1'b1),
    "issue counter ran past the term count")
  `CMMA_ASSERT(a_result_source, !$rose(m_valid_q) || ($past(state_q) == ST_FINISH),
    "result appeared without a finished computation")
  `CMMA_ASSERT_NEXT(a_compute_starts, in_acc && in_cmd == CMD_COMPUTE,
    state_q == ST_RUN, "compute request did not start the sequencer")

endmodule
